// ===== hw/rtl/gstg_pkg.sv =====
package gstg_pkg;

    // fixed point formats
    localparam int WEIGHT_BITS = 16;
    localparam int VALUE_BITS  = 16;
    localparam int COORD_BITS  = 32;
    localparam int LEVEL_BITS  = 4;
    localparam int LEVEL_MAX   = 15;
    localparam int FIELD_BITS  = 11;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [WEIGHT_BITS-1:0]       weight_t;
    typedef logic [LEVEL_BITS-1:0]        level_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_X        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_Y        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_Z        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COUNTS  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_LEVEL   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CORNERS_LOW  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CORNERS_HIGH = 3'd6;

    // one cell along each axis
    localparam logic [3*FIELD_BITS-1:0] GRID_COUNTS_RESET = 33'd4196353;

    // weight divider axis
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // lerp passes: four along x, two along y, one along z
    typedef enum logic [2:0] {
        STEP_XA,
        STEP_XB,
        STEP_XC,
        STEP_XD,
        STEP_YLO,
        STEP_YHI,
        STEP_Z
    } step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LERP_GO,
        ST_LERP_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/gstg_if.sv =====
interface gstg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface gstg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic [3:0]         cell_level;
    logic signed [15:0] value;
    logic               last;

    modport source (output valid, output cell_x, output cell_y, output cell_z,
                    output cell_level, output value, output last, input ready);
    modport sink (input valid, input cell_x, input cell_y, input cell_z,
                  input cell_level, input value, input last, output ready);
endinterface

// ===== hw/rtl/gstg_div.sv =====
module gstg_div
    import gstg_pkg::*;
#(
    parameter int DW = 26,
    parameter int QW = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0] trial;
    logic        fits;

    // restoring division, one quotient bit a cycle; num < den on entry
    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/gstg_lerp.sv =====
module gstg_lerp
    import gstg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  value_t  a,
    input  value_t  b,
    input  weight_t w,
    output logic    done,
    output value_t  y
);

    localparam int PROD_W = VALUE_BITS + WEIGHT_BITS + 2;

    logic signed [VALUE_BITS:0]  diff;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_reg;
    value_t                      a_reg;
    logic                        s1_valid_reg;
    logic                        done_reg;
    value_t                      y_reg;
    logic signed [PROD_W-1:0]    scaled;

    assign diff = $signed({b[VALUE_BITS-1], b}) - $signed({a[VALUE_BITS-1], a});
    assign prod = PROD_W'(diff * $signed({1'b0, w}));
    // arithmetic shift floors toward minus infinity
    assign scaled = prod_reg >>> WEIGHT_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod;
            a_reg    <= a;
        end
        // result lies between a and b, so the low bits are exact
        if (s1_valid_reg)
        begin
            y_reg <= a_reg + scaled[VALUE_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !s1_valid_reg && !done_reg)
        else $error("lerp started while a pass is in flight");

endmodule

// ===== hw/rtl/grid_scan_trilinear_generator_core.sv =====
// grid scan with trilinear fill
//
// req channel: one request per cell; restart=1 goes back to the first cell.
// rsp channel: one result per request with the cell coordinates
// min + index * 2^level, the level, the interpolated Q8.8 value and a last
// flag on the final cell. Cells run x fastest, then y, then z; the request
// after the last cell starts the scan again.
// cfg port: cfg_we writes cfg_data into register cfg_index; write only
// while no request is in flight.
// A request runs three weight divisions on the bit-serial divider (one
// quotient bit a cycle), seven lerps through the shared multiplier and
// one output step. One request is worked on at a time; req.ready is high
// only while the sequencer idles, so a new request is taken only once the
// previous result has been loaded into the output register.
// The result sits in an output register, so the next request is taken while
// rsp is stalled; a finished result waits there until rsp.ready.
// Reset clears the scan position to the first cell and loads the register
// defaults (one cell per axis, level 0, corners zero).
module grid_scan_trilinear_generator_core
    import gstg_pkg::*;
#(
    parameter int MAX_COUNT = 1024
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    gstg_req_if.sink                  req,
    gstg_rsp_if.source                rsp
);

    localparam int CNT_BITS = $clog2(MAX_COUNT + 1);
    localparam int CW       = (CNT_BITS > FIELD_BITS) ? CNT_BITS : FIELD_BITS;
    localparam int IDX_W    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int DW       = CW + LEVEL_MAX;

    // configuration
    logic [15:0]              min_x_reg, min_y_reg, min_z_reg;
    logic [3*FIELD_BITS-1:0]  grid_counts_reg;
    level_t                   grid_level_reg;
    logic [63:0]              corners_low_reg, corners_high_reg;

    // scan position and current cell
    logic [IDX_W-1:0] index_x_reg, index_y_reg, index_z_reg;
    logic [IDX_W-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic             last_reg;

    state_t  state_reg, state_next;
    axis_t   axis_reg;
    step_t   step_reg;
    weight_t wx_reg, wy_reg, wz_reg;
    value_t  la_reg, lb_reg, lc_reg, ld_reg, llo_reg, lhi_reg;

    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    level_t                       out_level_reg;
    value_t                       out_value_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;

    logic accept, div_start, lerp_start, load_out;

    function automatic logic [CW-1:0] sat_count(input logic [FIELD_BITS-1:0] f);
        logic [CW-1:0] e;
        e = CW'(f);
        if (e == '0)
            e = CW'(1);
        else if (e > CW'(MAX_COUNT))
            e = CW'(MAX_COUNT);
        return e;
    endfunction

    logic [CW-1:0] nx, ny, nz;
    assign nx = sat_count(grid_counts_reg[FIELD_BITS-1:0]);
    assign ny = sat_count(grid_counts_reg[2*FIELD_BITS-1:FIELD_BITS]);
    assign nz = sat_count(grid_counts_reg[3*FIELD_BITS-1:2*FIELD_BITS]);

    // effective position: restart or a stale position starts over
    logic          stale, at_end, x_wrap, y_wrap;
    logic [IDX_W-1:0] ex, ey, ez;
    assign stale = req.restart || (CW'(index_x_reg) >= nx) || (CW'(index_y_reg) >= ny)
                   || (CW'(index_z_reg) >= nz);
    assign ex = stale ? '0 : index_x_reg;
    assign ey = stale ? '0 : index_y_reg;
    assign ez = stale ? '0 : index_z_reg;
    assign x_wrap = (CW'(ex) + CW'(1)) >= nx;
    assign y_wrap = (CW'(ey) + CW'(1)) >= ny;
    assign at_end = (CW'(ex) == nx - CW'(1)) && (CW'(ey) == ny - CW'(1))
                    && (CW'(ez) == nz - CW'(1));

    // weight divider operands
    logic [IDX_W-1:0] div_idx;
    logic [CW-1:0]    div_cnt;
    logic [DW-1:0]    div_num, div_den;
    logic             div_done;
    weight_t          div_quot;

    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                div_idx = cur_x_reg;
                div_cnt = nx;
            end
            AXIS_Y:
            begin
                div_idx = cur_y_reg;
                div_cnt = ny;
            end
            default:
            begin
                div_idx = cur_z_reg;
                div_cnt = nz;
            end
        endcase
    end

    assign div_num = DW'(div_idx) << grid_level_reg;
    assign div_den = (DW'(div_cnt - CW'(1)) << grid_level_reg) + DW'(1);

    gstg_div #(
        .DW (DW),
        .QW (WEIGHT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // lerp operands per pass
    value_t  lerp_a, lerp_b, lerp_y;
    weight_t lerp_w;
    logic    lerp_done;

    always_comb
    begin
        case (step_reg)
            STEP_XA:
            begin
                lerp_a = corners_low_reg[15:0];
                lerp_b = corners_low_reg[31:16];
                lerp_w = wx_reg;
            end
            STEP_XB:
            begin
                lerp_a = corners_low_reg[47:32];
                lerp_b = corners_low_reg[63:48];
                lerp_w = wx_reg;
            end
            STEP_XC:
            begin
                lerp_a = corners_high_reg[15:0];
                lerp_b = corners_high_reg[31:16];
                lerp_w = wx_reg;
            end
            STEP_XD:
            begin
                lerp_a = corners_high_reg[47:32];
                lerp_b = corners_high_reg[63:48];
                lerp_w = wx_reg;
            end
            STEP_YLO:
            begin
                lerp_a = la_reg;
                lerp_b = lb_reg;
                lerp_w = wy_reg;
            end
            STEP_YHI:
            begin
                lerp_a = lc_reg;
                lerp_b = ld_reg;
                lerp_w = wy_reg;
            end
            default:
            begin
                lerp_a = llo_reg;
                lerp_b = lhi_reg;
                lerp_w = wz_reg;
            end
        endcase
    end

    gstg_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .a     (lerp_a),
        .b     (lerp_b),
        .w     (lerp_w),
        .done  (lerp_done),
        .y     (lerp_y)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        div_start  = 1'b0;
        lerp_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                accept = req.valid;
                if (req.valid)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == AXIS_Z) ? ST_LERP_GO : ST_DIV_GO;
            end
            ST_LERP_GO:
            begin
                lerp_start = 1'b1;
                state_next = ST_LERP_WAIT;
            end
            ST_LERP_WAIT:
            begin
                if (lerp_done)
                    state_next = (step_reg == STEP_Z) ? ST_OUT : ST_LERP_GO;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg        <= '0;
            min_y_reg        <= '0;
            min_z_reg        <= '0;
            grid_counts_reg  <= GRID_COUNTS_RESET;
            grid_level_reg   <= '0;
            corners_low_reg  <= '0;
            corners_high_reg <= '0;
            index_x_reg      <= '0;
            index_y_reg      <= '0;
            index_z_reg      <= '0;
            axis_reg         <= AXIS_X;
            step_reg         <= STEP_XA;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_X:        min_x_reg        <= cfg_data[15:0];
                    REG_MIN_Y:        min_y_reg        <= cfg_data[15:0];
                    REG_MIN_Z:        min_z_reg        <= cfg_data[15:0];
                    REG_GRID_COUNTS:  grid_counts_reg  <= cfg_data[3*FIELD_BITS-1:0];
                    REG_GRID_LEVEL:   grid_level_reg   <= cfg_data[LEVEL_BITS-1:0];
                    REG_CORNERS_LOW:  corners_low_reg  <= cfg_data;
                    REG_CORNERS_HIGH: corners_high_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                axis_reg <= AXIS_X;
                step_reg <= STEP_XA;
                if (at_end)
                begin
                    index_x_reg <= '0;
                    index_y_reg <= '0;
                    index_z_reg <= '0;
                end
                else if (!x_wrap)
                begin
                    index_x_reg <= ex + 1'b1;
                    index_y_reg <= ey;
                    index_z_reg <= ez;
                end
                else if (!y_wrap)
                begin
                    index_x_reg <= '0;
                    index_y_reg <= ey + 1'b1;
                    index_z_reg <= ez;
                end
                else
                begin
                    index_x_reg <= '0;
                    index_y_reg <= '0;
                    index_z_reg <= ez + 1'b1;
                end
            end
            if (state_reg == ST_DIV_WAIT && div_done)
            begin
                case (axis_reg)
                    AXIS_X:  axis_reg <= AXIS_Y;
                    default: axis_reg <= AXIS_Z;
                endcase
            end
            if (state_reg == ST_LERP_WAIT && lerp_done && step_reg != STEP_Z)
                step_reg <= step_t'(step_reg + 3'd1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= ex;
            cur_y_reg <= ey;
            cur_z_reg <= ez;
            last_reg  <= at_end;
        end
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            case (axis_reg)
                AXIS_X:  wx_reg <= div_quot;
                AXIS_Y:  wy_reg <= div_quot;
                default: wz_reg <= div_quot;
            endcase
        end
        if (state_reg == ST_LERP_WAIT && lerp_done)
        begin
            case (step_reg)
                STEP_XA:  la_reg  <= lerp_y;
                STEP_XB:  lb_reg  <= lerp_y;
                STEP_XC:  lc_reg  <= lerp_y;
                STEP_XD:  ld_reg  <= lerp_y;
                STEP_YLO: llo_reg <= lerp_y;
                STEP_YHI: lhi_reg <= lerp_y;
                // final pass stays in the lerp output until the result is loaded
                default:  ;
            endcase
        end
        if (load_out)
        begin
            out_x_reg     <= {{(COORD_BITS-16){min_x_reg[15]}}, min_x_reg}
                             + (COORD_BITS'(cur_x_reg) << grid_level_reg);
            out_y_reg     <= {{(COORD_BITS-16){min_y_reg[15]}}, min_y_reg}
                             + (COORD_BITS'(cur_y_reg) << grid_level_reg);
            out_z_reg     <= {{(COORD_BITS-16){min_z_reg[15]}}, min_z_reg}
                             + (COORD_BITS'(cur_z_reg) << grid_level_reg);
            out_level_reg <= grid_level_reg;
            out_value_reg <= lerp_y;
            out_last_reg  <= last_reg;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_x     = out_x_reg;
    assign rsp.cell_y     = out_y_reg;
    assign rsp.cell_z     = out_z_reg;
    assign rsp.cell_level = out_level_reg;
    assign rsp.value      = out_value_reg;
    assign rsp.last       = out_last_reg;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while a cell is in flight");

    a_result_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.value)
            && $stable(rsp.cell_x) && $stable(rsp.last))
        else $error("stalled result changed");

endmodule
